// ===== design/lpmf_pkg.sv =====
// Package: shared types, constants and register codes for the line pattern match filter.
`timescale 1ns / 1ps

package lpmf_pkg;

	localparam int MAX_PATTERN_DEF = 8;
	localparam int LEN_W           = 4;
	localparam int PBYTES_W        = 64;
	localparam int DATA_W          = 64;
	localparam int ADDR_W          = 5;
	localparam int REG_IDX_W       = 2;
	localparam int LINE_W          = 10;
	localparam int TOTAL_W         = 32;

	localparam logic [LINE_W-1:0]  LINE_MAX  = '1;
	localparam logic [TOTAL_W-1:0] TOTAL_MAX = '1;

	localparam logic [1:0] MODE_COUNT  = 2'd0;
	localparam logic [1:0] MODE_SELECT = 2'd1;
	localparam logic [1:0] MODE_INVERT = 2'd2;

	localparam logic [REG_IDX_W-1:0] REG_MODE    = 2'd0;
	localparam logic [REG_IDX_W-1:0] REG_PLEN    = 2'd1;
	localparam logic [REG_IDX_W-1:0] REG_PBYTES  = 2'd2;

	typedef struct packed {
		logic [7:0] text_byte;
		logic       line_end;
	} text_t;

	typedef struct packed {
		logic [LINE_W-1:0]  line_hits;
		logic [TOTAL_W-1:0] total_hits;
		logic               line_matched;
		logic               line_selected;
	} result_t;

endpackage

// ===== design/lpmf_match.sv =====
// Parallel compare of the byte window against the configured pattern.
`timescale 1ns / 1ps

module lpmf_match #(
	parameter int MAX_PATTERN = lpmf_pkg::MAX_PATTERN_DEF
) (
	input  logic [MAX_PATTERN-1:0][7:0]              window,
	input  logic [$clog2(MAX_PATTERN+1)-1:0]         fill,
	input  logic [lpmf_pkg::LEN_W-1:0]               pattern_length,
	input  logic [lpmf_pkg::PBYTES_W-1:0]            pattern_bytes,
	output logic                                     hit
);
	import lpmf_pkg::*;

	logic [LEN_W-1:0]       alen;
	logic [MAX_PATTERN-1:0] eq;

	// lengths above the window size clamp to the window size
	assign alen = (pattern_length > LEN_W'(MAX_PATTERN)) ? LEN_W'(MAX_PATTERN) : pattern_length;

	// eq[k]: last k+1 bytes equal the first k+1 pattern bytes, oldest first
	always_comb begin
		for (int k = 0; k < MAX_PATTERN; k++) begin
			eq[k] = 1'b1;
			for (int i = 0; i <= k; i++) begin
				if (window[k-i] != pattern_bytes[8*i +: 8]) begin
					eq[k] = 1'b0;
				end
			end
		end
	end

	always_comb begin
		hit = 1'b0;
		for (int k = 0; k < MAX_PATTERN; k++) begin
			if (alen == LEN_W'(k + 1) && eq[k]) begin
				hit = 1'b1;
			end
		end
		if (alen == '0 || LEN_W'(fill) < alen) begin
			hit = 1'b0;
		end
	end

endmodule

// ===== design/line_pattern_match_filter.sv =====
// Top level: line-framed substring counter with match / invert line selection.
//
//  channel  | handshake                  | payload
//  ---------+----------------------------+------------------------------------
//  text     | text_valid / text_stall    | text_byte, line_end
//  result   | result_valid / result_stall| line_hits, total_hits, matched, sel
//  config   | APB psel/penable/pwrite    | mode @0, pattern_length @8, bytes @16
//
//  One byte per cycle sustained. Path: input register, then window compare and
//  counter update into the result register. Only bytes with line_end wait on a
//  stalled result register; other bytes always drain. arst_n resets control
//  state and the config registers; pattern_length resets to 1.
`timescale 1ns / 1ps

module line_pattern_match_filter #(
	parameter int MAX_PATTERN = lpmf_pkg::MAX_PATTERN_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           text_valid,
	output logic                           text_stall,
	input  lpmf_pkg::text_t                text,
	output logic                           result_valid,
	input  logic                           result_stall,
	output lpmf_pkg::result_t              result,
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [lpmf_pkg::ADDR_W-1:0]    paddr,
	input  logic [lpmf_pkg::DATA_W-1:0]    pwdata,
	output logic [lpmf_pkg::DATA_W-1:0]    prdata,
	output logic                           pready
);
	import lpmf_pkg::*;

	localparam int FILL_W = $clog2(MAX_PATTERN + 1);

	logic [1:0]          mode_q;
	logic [LEN_W-1:0]    plen_q;
	logic [PBYTES_W-1:0] pbytes_q;
	logic [REG_IDX_W-1:0] reg_idx;
	logic                cfg_wr;

	logic  valid_s1;
	text_t text_s1;
	logic  out_free;
	logic  advance;
	logic  take;

	logic [MAX_PATTERN-1:0][7:0] window_q;
	logic [MAX_PATTERN-1:0][7:0] win_next;
	logic [FILL_W-1:0]           fill_q;
	logic [FILL_W-1:0]           fill_next;
	logic                        hit;

	logic [LINE_W-1:0]  line_q;
	logic [LINE_W-1:0]  line_next;
	logic [TOTAL_W-1:0] total_q;
	logic [TOTAL_W-1:0] total_next;
	logic               matched;
	logic               selected;

	logic    result_valid_q;
	result_t result_q;

	// configuration port
	assign pready  = 1'b1;
	assign reg_idx = paddr[ADDR_W-1:3];
	assign cfg_wr  = psel & penable & pwrite & pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= MODE_COUNT;
			plen_q   <= LEN_W'(1);
			pbytes_q <= '0;
		end else if (cfg_wr) begin
			case (reg_idx)
				REG_MODE:   mode_q   <= pwdata[1:0];
				REG_PLEN:   plen_q   <= pwdata[LEN_W-1:0];
				REG_PBYTES: pbytes_q <= pwdata[PBYTES_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			REG_MODE:   prdata = DATA_W'(mode_q);
			REG_PLEN:   prdata = DATA_W'(plen_q);
			REG_PBYTES: prdata = DATA_W'(pbytes_q);
			default:    prdata = '0;
		endcase
	end

	// input register and flow control
	assign out_free   = ~result_valid_q | ~result_stall;
	assign advance    = valid_s1 & (~text_s1.line_end | out_free);
	assign text_stall = valid_s1 & ~advance;
	assign take       = text_valid & ~text_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			text_s1 <= text;
		end
	end

	// window shift and match
	always_comb begin
		win_next[0] = text_s1.text_byte;
		for (int i = 1; i < MAX_PATTERN; i++) begin
			win_next[i] = window_q[i-1];
		end
	end

	assign fill_next = (fill_q == FILL_W'(MAX_PATTERN)) ? fill_q : fill_q + 1'b1;

	lpmf_match #(
		.MAX_PATTERN(MAX_PATTERN)
	) u_match (
		.window         (win_next),
		.fill           (fill_next),
		.pattern_length (plen_q),
		.pattern_bytes  (pbytes_q),
		.hit            (hit)
	);

	assign line_next  = line_q + LINE_W'(hit && line_q != LINE_MAX);
	assign total_next = total_q + TOTAL_W'(hit && total_q != TOTAL_MAX);
	assign matched    = line_next != '0;
	assign selected   = (mode_q == MODE_SELECT && matched) ||
	                    (mode_q == MODE_INVERT && !matched);

	always_ff @(posedge clk) begin
		if (advance) begin
			window_q <= win_next;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q  <= '0;
			line_q  <= '0;
			total_q <= '0;
		end else if (advance) begin
			fill_q  <= text_s1.line_end ? '0 : fill_next;
			line_q  <= text_s1.line_end ? '0 : line_next;
			total_q <= total_next;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (advance && text_s1.line_end) begin
			result_valid_q <= 1'b1;
		end else if (!result_stall) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && text_s1.line_end) begin
			result_q.line_hits     <= line_next;
			result_q.total_hits    <= total_next;
			result_q.line_matched  <= matched;
			result_q.line_selected <= selected;
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

endmodule

// ===== design/lpmf_checker.sv =====
// Port-level checker for the line pattern match filter, with its bind.
`timescale 1ns / 1ps

module lpmf_checker (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        text_valid,
	input logic                        text_stall,
	input lpmf_pkg::text_t             text,
	input logic                        result_valid,
	input logic                        result_stall,
	input lpmf_pkg::result_t           result
);
	import lpmf_pkg::*;

	// a stalled text transaction holds
	a_text_hold: assert property (@(posedge clk) disable iff (!arst_n)
		text_valid && text_stall |=> text_valid && $stable(text))
		else $error("text changed while stalled");

	// a stalled result transaction holds
	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid && $stable(result))
		else $error("result changed while stalled");

	a_matched_hits: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> result.line_matched == (result.line_hits != '0))
		else $error("line_matched disagrees with line_hits");

	a_total_ge_line: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> result.total_hits >= TOTAL_W'(result.line_hits))
		else $error("total_hits below line_hits");

	// no input stall while the result register is empty
	a_no_stall_idle: assert property (@(posedge clk) disable iff (!arst_n)
		!result_valid |-> !text_stall)
		else $error("text stalled with free result register");

endmodule

bind line_pattern_match_filter lpmf_checker u_lpmf_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.text_valid   (text_valid),
	.text_stall   (text_stall),
	.text         (text),
	.result_valid (result_valid),
	.result_stall (result_stall),
	.result       (result)
);

// ===== verif/line_pattern_match_filter_test.sv =====
// Testbench: line_pattern_match_filter line results checked against a line hit predictor fed byte by byte.
`timescale 1ns / 1ps

module line_pattern_match_filter_test;
	import lpmf_pkg::*;

	localparam int CYCLE_LIMIT  = 300000;
	localparam int FLUSH_CYCLES = 6;
	localparam int RANDOM_ITEMS = 1600;
	localparam int PHASE_ITEMS  = 50;
	localparam int HOLD_CYCLES  = 400;
	localparam int SAT_LINE_LEN = 1030;

	localparam logic [REG_IDX_W-1:0] REG_SPARE  = 2'd3;
	localparam logic [1:0]           MODE_SPARE = 2'd3;

	class line_hit_scoreboard;
		logic [1:0]         mode;
		logic [LEN_W-1:0]   plen;
		logic [63:0]        pbytes;
		logic [7:0]         recent [MAX_PATTERN_DEF];
		int unsigned        fill;
		logic [LINE_W-1:0]  line_count;
		logic [TOTAL_W-1:0] total_count;
		result_t            expected_lines [$];
		int                 mismatches;

		function new();
			mode = MODE_COUNT;
			plen = 4'd1;
			pbytes = '0;
			total_count = '0;
			mismatches = 0;
			clear_line();
		endfunction

		function void clear_line();
			foreach (recent[i]) recent[i] = 8'h00;
			fill = 0;
			line_count = '0;
		endfunction

		function void write_reg(logic [REG_IDX_W-1:0] idx, logic [63:0] value);
			case (idx)
				REG_MODE: mode = value[1:0];
				REG_PLEN: plen = value[LEN_W-1:0];
				REG_PBYTES: pbytes = value;
				default: ;
			endcase
		endfunction

		function void note_byte(text_t t);
			int      n;
			bit      hit;
			result_t r;
			for (int i = MAX_PATTERN_DEF - 1; i > 0; i--)
				recent[i] = recent[i-1];
			recent[0] = t.text_byte;
			if (fill < MAX_PATTERN_DEF)
				fill++;
			n = (plen > MAX_PATTERN_DEF) ? MAX_PATTERN_DEF : plen;
			hit = (n != 0) && (fill >= n);
			for (int i = 0; i < n; i++)
				if (recent[n-1-i] != pbytes[8*i +: 8])
					hit = 0;
			if (hit) begin
				if (line_count != LINE_MAX)
					line_count++;
				if (total_count != TOTAL_MAX)
					total_count++;
			end
			if (t.line_end) begin
				r.line_hits = line_count;
				r.total_hits = total_count;
				r.line_matched = (line_count != 0);
				r.line_selected = (mode == MODE_SELECT && r.line_matched) ||
					(mode == MODE_INVERT && !r.line_matched);
				expected_lines.push_back(r);
				clear_line();
			end
		endfunction

		function void check_line(result_t got);
			result_t want;
			if (expected_lines.size() == 0) begin
				$error("unexpected line result: line_hits %0d total_hits %0d",
					got.line_hits, got.total_hits);
				mismatches++;
				return;
			end
			want = expected_lines.pop_front();
			if (got.line_hits !== want.line_hits) begin
				$error("line_hits: expected %0d, actual %0d", want.line_hits, got.line_hits);
				mismatches++;
			end
			if (got.total_hits !== want.total_hits) begin
				$error("total_hits: expected %0d, actual %0d", want.total_hits, got.total_hits);
				mismatches++;
			end
			if (got.line_matched !== want.line_matched) begin
				$error("line_matched: expected %0d, actual %0d",
					want.line_matched, got.line_matched);
				mismatches++;
			end
			if (got.line_selected !== want.line_selected) begin
				$error("line_selected: expected %0d, actual %0d",
					want.line_selected, got.line_selected);
				mismatches++;
			end
		endfunction
	endclass

	logic                clk;
	logic                arst_n = 1'b0;
	logic                text_valid = 1'b0;
	logic                text_stall;
	text_t               text = '0;
	logic                result_valid;
	logic                result_stall = 1'b0;
	result_t             result;
	logic                psel = 1'b0;
	logic                penable = 1'b0;
	logic                pwrite = 1'b0;
	logic [ADDR_W-1:0]   paddr = '0;
	logic [DATA_W-1:0]   pwdata = '0;
	logic [DATA_W-1:0]   prdata;
	logic                pready;

	line_hit_scoreboard sb = new();

	int          send_pct = 0;
	int          recv_pct = 0;
	int          hold_left = 0;
	int          items_sent = 0;
	int          cycles = 0;
	logic [3:0]  pat_len;
	logic [63:0] pat_bytes;

	line_pattern_match_filter uut (.*);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("line_pattern_match_filter regression: fail");
			$finish;
		end
	end

	// result side: check, then pick the stall for the next cycle
	always @(posedge clk) begin
		if (arst_n && result_valid && !result_stall)
			sb.check_line(result);
		if (hold_left > 0) begin
			hold_left = hold_left - 1;
			result_stall <= 1'b1;
		end else begin
			result_stall <= ($urandom_range(99) < recv_pct);
		end
	end

	task automatic send_byte(logic [7:0] b, logic last);
		text_t t;
		t.text_byte = b;
		t.line_end = last;
		while ($urandom_range(99) < send_pct) begin
			text_valid <= 1'b0;
			@(posedge clk);
		end
		text_valid <= 1'b1;
		text <= t;
		@(posedge clk);
		while (text_stall)
			@(posedge clk);
		sb.note_byte(t);
		items_sent++;
	endtask

	task automatic send_text(string s);
		for (int i = 0; i < s.len(); i++)
			send_byte(s[i], i == s.len() - 1);
	endtask

	task automatic wait_idle();
		text_valid <= 1'b0;
		while (sb.expected_lines.size() != 0)
			@(posedge clk);
		repeat (FLUSH_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(logic [REG_IDX_W-1:0] idx, logic [63:0] value);
		wait_idle();
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 3'b000};
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		sb.write_reg(idx, value);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	// lines built from pattern copies, pattern bytes and noise
	task automatic send_random_line(int len);
		int         n;
		int         k;
		int         roll;
		logic [7:0] b;
		n = (pat_len > MAX_PATTERN_DEF) ? MAX_PATTERN_DEF : pat_len;
		if (n == 0)
			n = 1;
		k = 0;
		while (k < len) begin
			roll = $urandom_range(99);
			if (roll < 35) begin
				for (int j = 0; j < n && k < len; j++) begin
					send_byte(pat_bytes[8*j +: 8], k == len - 1);
					k++;
				end
			end else begin
				if (roll < 70)
					b = pat_bytes[8*$urandom_range(n-1) +: 8];
				else
					b = 8'($urandom_range(255));
				send_byte(b, k == len - 1);
				k++;
			end
		end
	endtask

	task automatic pick_pattern();
		logic [7:0] b;
		case ($urandom_range(2))
			0: pat_bytes = {$urandom, $urandom};
			1: begin
				b = 8'($urandom_range(255));
				pat_bytes = {8{b}};
			end
			default: begin
				for (int j = 0; j < 8; j++)
					pat_bytes[8*j +: 8] = $urandom_range(1) ? 8'h61 : 8'h62;
			end
		endcase
	endtask

	task automatic random_phase(int p);
		int extremes [6] = '{1, 8, 0, 15, 2, 7};
		int idle_sel;
		int start;
		int len;
		if (p < 6)
			pat_len = 4'(extremes[p]);
		else if ($urandom_range(4) == 0)
			pat_len = 4'($urandom_range(15));
		else
			pat_len = 4'($urandom_range(8, 1));
		pick_pattern();
		write_reg(REG_MODE, (p < 4) ? p : $urandom_range(3));
		write_reg(REG_PLEN, pat_len);
		write_reg(REG_PBYTES, pat_bytes);
		idle_sel = (p / 4 + p) % 4;
		send_pct = (idle_sel == 1) ? 64 : (idle_sel == 3) ? 16 : 0;
		recv_pct = (idle_sel == 2) ? 64 : (idle_sel == 3) ? 16 : 0;
		start = items_sent;
		while (items_sent - start < PHASE_ITEMS) begin
			len = ($urandom_range(9) == 0) ? $urandom_range(40, 13) : $urandom_range(12, 1);
			send_random_line(len);
		end
	endtask

	initial begin
		int p;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings: count mode, one zero pattern byte; window fill guards the zeros
		send_byte(8'h00, 1'b0);
		send_byte(8'h00, 1'b1);
		send_byte(8'hFF, 1'b1);

		// bytes past the length are ignored; a hit on the last byte counts
		write_reg(REG_MODE, MODE_SELECT);
		write_reg(REG_PLEN, 4'd3);
		write_reg(REG_PBYTES, 64'hDEAD_BEEF_C363_6261);
		send_text("xabcabc");

		write_reg(REG_PLEN, 4'd2);
		write_reg(REG_PBYTES, 64'h6161);
		send_text("aaaa");

		// no match across a line boundary
		write_reg(REG_MODE, MODE_INVERT);
		write_reg(REG_PLEN, 4'd3);
		write_reg(REG_PBYTES, 64'h63_6261);
		send_text("ab");
		send_text("c");

		// zero length never matches
		write_reg(REG_PLEN, 4'd0);
		write_reg(REG_PBYTES, 64'h0);
		send_byte(8'h00, 1'b1);

		// length above the window size acts as full size; spare mode counts only
		write_reg(REG_MODE, MODE_SPARE);
		write_reg(REG_PLEN, 4'd15);
		write_reg(REG_PBYTES, 64'h00FF_00FF_FF00_FF00);
		for (int i = 0; i < 8; i++)
			send_byte(sb.pbytes[8*i +: 8], i == 7);

		// pattern change inside a line
		write_reg(REG_MODE, MODE_SELECT);
		write_reg(REG_PLEN, 4'd1);
		write_reg(REG_PBYTES, 64'h78);
		send_byte(8'h78, 1'b0);
		write_reg(REG_PBYTES, 64'h79);
		send_byte(8'h79, 1'b1);

		// unmapped register write is dropped
		write_reg(REG_SPARE, '1);
		send_text("yy");

		items_sent = 0;
		p = 0;
		while (items_sent < RANDOM_ITEMS) begin
			random_phase(p);
			if (p == 5) begin
				// long result hold-off with short lines to back up the input
				wait_idle();
				send_pct = 0;
				hold_left = HOLD_CYCLES;
				for (int i = 0; i < 60; i++)
					send_random_line($urandom_range(2, 1));
			end
			if (p == 9) begin
				// line_hits saturation
				write_reg(REG_MODE, MODE_SELECT);
				write_reg(REG_PLEN, 4'd1);
				write_reg(REG_PBYTES, {$urandom, 24'h0, 8'h2A});
				send_pct = 0;
				for (int i = 0; i < SAT_LINE_LEN; i++)
					send_byte(8'h2A, i == SAT_LINE_LEN - 1);
			end
			p++;
		end

		wait_idle();
		if (sb.mismatches == 0 && sb.expected_lines.size() == 0)
			$display("line_pattern_match_filter regression: pass");
		else
			$display("line_pattern_match_filter regression: fail");
		$finish;
	end

endmodule
